@@ design/cmad_pkg.sv @@
// Shared types, constants and helper functions for the calendar minute accumulator.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package cmad_pkg;

	// Field widths of the transaction payloads and of the configuration port.
	localparam int YEAR_W     = 14;
	localparam int MONTH_W    = 4;
	localparam int DAY_W      = 5;
	localparam int HOUR_W     = 5;
	localparam int MINUTE_W   = 6;
	localparam int DUR_W      = 20;
	localparam int FIT_W      = 13;
	localparam int DAYS_W     = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	// Constant divider: x * K >> S underestimates the quotient by at most one.
	localparam int DIV_X_W = 21;
	localparam int DIV_K_W = 22;
	localparam int DIV_P_W = DIV_X_W + DIV_K_W;
	localparam int DIV_Q_W = 16;
	localparam int DIV_R_W = 8;
	localparam int DIV_S_W = 5;
	localparam int DIV_D_W = 7;

	localparam logic [FIT_W-1:0]   MAX_ITEMS  = 13'd4096;
	localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
	localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd12;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DL_YEAR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DL_MONTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DL_DAY    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DL_HOUR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DL_MINUTE = 3'd4;

	typedef enum logic [1:0] {
		DIV_BY_60,
		DIV_BY_24,
		DIV_BY_100
	} div_sel_t;

	typedef struct packed {
		logic                mode;
		logic [YEAR_W-1:0]   start_year;
		logic [MONTH_W-1:0]  start_month;
		logic [DAY_W-1:0]    start_day;
		logic [HOUR_W-1:0]   start_hour;
		logic [MINUTE_W-1:0] start_minute;
		logic [DUR_W-1:0]    duration;
	} cmad_in_t;

	typedef struct packed {
		logic [YEAR_W-1:0]   now_year;
		logic [MONTH_W-1:0]  now_month;
		logic [DAY_W-1:0]    now_day;
		logic [HOUR_W-1:0]   now_hour;
		logic [MINUTE_W-1:0] now_minute;
		logic [FIT_W-1:0]    fit_count;
		logic                exceeded;
	} cmad_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load;
		logic     start_add;
		logic     mul;
		logic     fix;
		div_sel_t sel;
		logic     day_step;
		logic     check;
		logic     load_out;
	} cmad_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic days_zero;
	} cmad_stat_t;

	function automatic logic [DIV_K_W-1:0] div_k(input div_sel_t sel);
		case (sel)
			DIV_BY_60:  return 22'd2236962;
			DIV_BY_24:  return 22'd43690;
			DIV_BY_100: return 22'd20971;
			default:    return 22'd0;
		endcase
	endfunction

	function automatic logic [DIV_S_W-1:0] div_shift(input div_sel_t sel);
		case (sel)
			DIV_BY_60:  return 5'd27;
			DIV_BY_24:  return 5'd20;
			DIV_BY_100: return 5'd21;
			default:    return 5'd0;
		endcase
	endfunction

	function automatic logic [DIV_D_W-1:0] div_d(input div_sel_t sel);
		case (sel)
			DIV_BY_60:  return 7'd60;
			DIV_BY_24:  return 7'd24;
			DIV_BY_100: return 7'd100;
			default:    return 7'd1;
		endcase
	endfunction

	// Leap year from the year split as 100 * q + r (only q modulo 4 is kept).
	function automatic logic leap_of(input logic [6:0] r100, input logic [1:0] q100);
		if (r100 == 7'd0) begin
			return (q100 == 2'd0);
		end
		return (r100[1:0] == 2'd0);
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic lp, input logic [MONTH_W-1:0] mi);
		case (mi)
			4'd2:                      return lp ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   return 5'd30;
			default:                   return 5'd31;
		endcase
	endfunction

endpackage

@@ design/cmad_if.sv @@
// Valid/ready channel interfaces for the request and response transactions.
// Depends on cmad_pkg for the payload types.
`timescale 1ns / 1ps

interface cmad_req_if import cmad_pkg::*; ();
	logic     valid;
	logic     ready;
	cmad_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cmad_rsp_if import cmad_pkg::*; ();
	logic      valid;
	logic      ready;
	cmad_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/cmad_datapath.sv @@
// Datapath: current date-time, shared constant divider, day stepper, deadline check
// and the response register. Depends on cmad_pkg; driven by cmad_ctrl commands.
`timescale 1ns / 1ps

module cmad_datapath import cmad_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmad_cmd_t             cmd,
	output cmad_stat_t            stat,
	input  cmad_in_t              item,
	input  logic                  write_en,
	input  logic [CFG_IDX_W-1:0]  write_index,
	input  logic [CFG_DATA_W-1:0] write_data,
	output cmad_out_t             result
);

	logic [YEAR_W-1:0]   cur_year_q;
	logic [MONTH_W-1:0]  cur_month_q;
	logic [DAY_W-1:0]    cur_day_q;
	logic [HOUR_W-1:0]   cur_hour_q;
	logic [MINUTE_W-1:0] cur_minute_q;
	logic [6:0]          r100_q;
	logic [1:0]          q100_q;
	logic [DAYS_W-1:0]   days_q;
	logic [FIT_W-1:0]    fitted_q;
	logic                over_q;

	logic [YEAR_W-1:0]   dl_year_q;
	logic [MONTH_W-1:0]  dl_month_q;
	logic [DAY_W-1:0]    dl_day_q;
	logic [HOUR_W-1:0]   dl_hour_q;
	logic [MINUTE_W-1:0] dl_minute_q;

	logic [DIV_X_W-1:0]  x_q;
	logic [DIV_P_W-1:0]  prod_q;
	cmad_out_t           result_q;

	logic [DIV_K_W-1:0]  k;
	logic [DIV_S_W-1:0]  sh;
	logic [DIV_D_W-1:0]  d;
	logic [DIV_Q_W-1:0]  q_est;
	logic [DIV_X_W-1:0]  qd;
	logic [DIV_X_W-1:0]  r_full;
	logic [DIV_Q_W-1:0]  q_fix;
	logic [DIV_R_W-1:0]  r_fix;

	logic [YEAR_W-1:0]   ld_year;
	logic [MONTH_W-1:0]  ld_month;
	logic [DAY_W-1:0]    ld_day;
	logic [HOUR_W-1:0]   ld_hour;
	logic [MINUTE_W-1:0] ld_minute;

	logic                lp;
	logic [MONTH_W-1:0]  mi;
	logic [DAY_W-1:0]    mlen;
	logic [DAY_W:0]      day_inc;
	logic                at_end;
	logic                past;

	// Constant divider, second half: correct the estimate by one step at most.
	always_comb begin
		k      = div_k(cmd.sel);
		sh     = div_shift(cmd.sel);
		d      = div_d(cmd.sel);
		q_est  = DIV_Q_W'(prod_q >> sh);
		qd     = DIV_X_W'(q_est) * DIV_X_W'(d);
		r_full = x_q - qd;
		if (r_full >= DIV_X_W'(d)) begin
			q_fix = q_est + DIV_Q_W'(1);
			r_fix = DIV_R_W'(r_full - DIV_X_W'(d));
		end else begin
			q_fix = q_est;
			r_fix = DIV_R_W'(r_full);
		end
	end

	// Clamp the start fields of a load transaction into range (the day only up from zero).
	always_comb begin
		ld_year = item.start_year;
		if (item.start_year == '0) begin
			ld_year = 14'd1;
		end else if (item.start_year > YEAR_MAX) begin
			ld_year = YEAR_MAX;
		end
		ld_month = item.start_month;
		if (item.start_month == '0) begin
			ld_month = 4'd1;
		end else if (item.start_month > MONTH_LAST) begin
			ld_month = MONTH_LAST;
		end
		ld_day  = (item.start_day == '0) ? 5'd1 : item.start_day;
		ld_hour = (item.start_hour > 5'd23) ? 5'd23 : item.start_hour;
		ld_minute = (item.start_minute > 6'd59) ? 6'd59 : item.start_minute;
	end

	// One calendar day step and the deadline comparison.
	always_comb begin
		lp      = leap_of(r100_q, q100_q);
		mi      = (cur_month_q >= 4'd1 && cur_month_q <= MONTH_LAST) ? cur_month_q : MONTH_LAST;
		mlen    = month_len(lp, mi);
		day_inc = {1'b0, cur_day_q} + 6'd1;
		at_end  = (cur_year_q >= YEAR_MAX) && (mi == MONTH_LAST) && (cur_day_q >= mlen);
		past    = {cur_year_q, cur_month_q, cur_day_q, cur_hour_q, cur_minute_q} >
		          {dl_year_q, dl_month_q, dl_day_q, dl_hour_q, dl_minute_q};
	end

	assign stat.days_zero = (days_q == '0);

	// Deadline configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dl_year_q   <= YEAR_MAX;
			dl_month_q  <= MONTH_LAST;
			dl_day_q    <= 5'd31;
			dl_hour_q   <= 5'd23;
			dl_minute_q <= 6'd59;
		end else if (write_en) begin
			case (write_index)
				REG_DL_YEAR:   dl_year_q   <= write_data[YEAR_W-1:0];
				REG_DL_MONTH:  dl_month_q  <= write_data[MONTH_W-1:0];
				REG_DL_DAY:    dl_day_q    <= write_data[DAY_W-1:0];
				REG_DL_HOUR:   dl_hour_q   <= write_data[HOUR_W-1:0];
				REG_DL_MINUTE: dl_minute_q <= write_data[MINUTE_W-1:0];
				default: ;
			endcase
		end
	end

	// Date-time state, day counter, fit count and exceeded flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_year_q   <= 14'd1;
			cur_month_q  <= 4'd1;
			cur_day_q    <= 5'd1;
			cur_hour_q   <= '0;
			cur_minute_q <= '0;
			r100_q       <= 7'd1;
			q100_q       <= '0;
			days_q       <= '0;
			fitted_q     <= '0;
			over_q       <= 1'b0;
		end else begin
			if (cmd.load) begin
				cur_year_q   <= ld_year;
				cur_month_q  <= ld_month;
				cur_day_q    <= ld_day;
				cur_hour_q   <= ld_hour;
				cur_minute_q <= ld_minute;
				days_q       <= '0;
				fitted_q     <= '0;
				over_q       <= 1'b0;
			end
			if (cmd.fix) begin
				case (cmd.sel)
					DIV_BY_60:  cur_minute_q <= MINUTE_W'(r_fix);
					DIV_BY_24: begin
						cur_hour_q <= HOUR_W'(r_fix);
						days_q     <= DAYS_W'(q_fix);
					end
					DIV_BY_100: begin
						r100_q <= 7'(r_fix);
						q100_q <= q_fix[1:0];
					end
					default: ;
				endcase
			end
			if (cmd.day_step) begin
				if (at_end) begin
					cur_year_q   <= YEAR_MAX;
					cur_month_q  <= MONTH_LAST;
					cur_day_q    <= 5'd31;
					cur_hour_q   <= 5'd23;
					cur_minute_q <= 6'd59;
					days_q       <= '0;
				end else begin
					days_q <= days_q - DAYS_W'(1);
					if (day_inc > {1'b0, mlen}) begin
						cur_day_q <= 5'd1;
						if (mi == MONTH_LAST) begin
							cur_month_q <= 4'd1;
							cur_year_q  <= cur_year_q + YEAR_W'(1);
							if (r100_q == 7'd99) begin
								r100_q <= '0;
								q100_q <= q100_q + 2'd1;
							end else begin
								r100_q <= r100_q + 7'd1;
							end
						end else begin
							cur_month_q <= mi + 4'd1;
						end
					end else begin
						cur_day_q <= DAY_W'(day_inc);
					end
				end
			end
			if (cmd.check && !over_q) begin
				if (past) begin
					over_q <= 1'b1;
				end else if (fitted_q < MAX_ITEMS) begin
					fitted_q <= fitted_q + FIT_W'(1);
				end
			end
		end
	end

	// Divider operand, product register and response register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= DIV_X_W'(ld_year);
		end else if (cmd.start_add) begin
			x_q <= DIV_X_W'(cur_minute_q) + DIV_X_W'(item.duration);
		end else if (cmd.fix && cmd.sel == DIV_BY_60) begin
			x_q <= DIV_X_W'(cur_hour_q) + DIV_X_W'(q_fix);
		end
		if (cmd.mul) begin
			prod_q <= DIV_P_W'(x_q) * DIV_P_W'(k);
		end
		if (cmd.load_out) begin
			result_q.now_year   <= cur_year_q;
			result_q.now_month  <= cur_month_q;
			result_q.now_day    <= cur_day_q;
			result_q.now_hour   <= cur_hour_q;
			result_q.now_minute <= cur_minute_q;
			result_q.fit_count  <= fitted_q;
			result_q.exceeded   <= over_q;
		end
	end

	assign result = result_q;

`ifndef SYNTH
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_minute_q <= 6'd59 && cur_hour_q <= 5'd23)
		else $error("time of day left its range");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_month_q >= 4'd1 && cur_month_q <= MONTH_LAST && cur_day_q != '0)
		else $error("month or day left its range");

	a_year_split: assert property (@(posedge clk) disable iff (!arst_n)
		r100_q <= 7'd99)
		else $error("year remainder modulo 100 out of range");

	a_count_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.check && over_q && !cmd.load) |=> (over_q && $stable(fitted_q)))
		else $error("fit count moved after the deadline was exceeded");
`endif

endmodule

@@ design/cmad_ctrl.sv @@
// Controller state machine: sequences loads, divisions, day steps and the response.
// Depends on cmad_pkg for the command and status structs.
`timescale 1ns / 1ps

module cmad_ctrl import cmad_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_mode,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  cmad_stat_t stat,
	output cmad_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIX,
		ST_DAYS,
		ST_CHECK,
		ST_DONE
	} state_t;

	state_t   state_q;
	div_sel_t pass_q;
	logic     out_valid_q;
	logic     accept;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = out_valid_q;

	// Command decode.
	always_comb begin
		cmd.load      = accept && !req_mode;
		cmd.start_add = accept && req_mode;
		cmd.mul       = (state_q == ST_MUL);
		cmd.fix       = (state_q == ST_FIX);
		cmd.sel       = pass_q;
		cmd.day_step  = (state_q == ST_DAYS) && !stat.days_zero;
		cmd.check     = (state_q == ST_CHECK);
		cmd.load_out  = (state_q == ST_DONE) && (!out_valid_q || rsp_ready);
	end

	// State, division pass and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= DIV_BY_60;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pass_q  <= req_mode ? DIV_BY_60 : DIV_BY_100;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_FIX;
				ST_FIX: begin
					unique case (pass_q)
						DIV_BY_60: begin
							pass_q  <= DIV_BY_24;
							state_q <= ST_MUL;
						end
						DIV_BY_24:  state_q <= ST_DAYS;
						DIV_BY_100: state_q <= ST_DONE;
						default:    state_q <= ST_IDLE;
					endcase
				end
				ST_DAYS: begin
					if (stat.days_zero) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: state_q <= ST_DONE;
				ST_DONE: begin
					if (cmd.load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_days_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> stat.days_zero)
		else $error("deadline check started with days still pending");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || rsp_ready))
		else $error("response register overwritten while still held");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("response raised outside the done state");
`endif

endmodule

@@ design/calendar_minute_accumulator_deadline_core.sv @@
// Top level of the calendar minute accumulator with deadline check.
// Depends on cmad_pkg, cmad_req_if, cmad_rsp_if, cmad_ctrl and cmad_datapath.
//
//   Channel   Direction  Handshake          Payload
//   req       in         valid / ready      cmad_in_t  (mode, start time, duration)
//   rsp       out        valid / ready      cmad_out_t (time, fit count, exceeded)
//   write_*   in         write_en only      deadline register index and data
//
// A load transaction goes through MUL, FIX and DONE, where the response register is filled;
// an add transaction through MUL and FIX twice, then DAYS, CHECK and DONE, DAYS stepping
// one day per cycle over the whole days carried (0 to 729), fewer if stopped at the calendar's end.
// One transaction is worked on at a time; req is ready again in the cycle after the
// response register is filled. A response still held on rsp delays that filling.
// Reset is asynchronous, active low, and needs no clearing pass.
`timescale 1ns / 1ps

module calendar_minute_accumulator_deadline_core import cmad_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	cmad_req_if.sink              req,
	cmad_rsp_if.source            rsp,
	input  logic                  write_en,
	input  logic [CFG_IDX_W-1:0]  write_index,
	input  logic [CFG_DATA_W-1:0] write_data
);

	cmad_cmd_t  cmd;
	cmad_stat_t stat;

	// Sequencer.
	cmad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_mode  (req.data.mode),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Calendar arithmetic and response register.
	cmad_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.item        (req.data),
		.write_en    (write_en),
		.write_index (write_index),
		.write_data  (write_data),
		.result      (rsp.data)
	);

endmodule
